/* rtl/core/assert_macros.svh */
// Assertion macros shared by the bridge arbiter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OLBA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define OLBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

/* rtl/core/olba_pkg.sv */
// Package: codes, config/state/result types for the bridge arbiter.
package olba_pkg;

	localparam int unsigned MaxWaitingDef = 255;

	localparam logic [2:0] OpArrive     = 3'd0;
	localparam logic [2:0] OpRequest    = 3'd1;
	localparam logic [2:0] OpExit       = 3'd2;
	localparam logic [2:0] OpSuspend    = 3'd3;
	localparam logic [2:0] OpResume     = 3'd4;
	localparam logic [2:0] OpSetSensor  = 3'd5;
	localparam logic [2:0] OpSetBarrier = 3'd6;

	localparam logic [2:0] StDone     = 3'd0;
	localparam logic [2:0] StGranted  = 3'd1;
	localparam logic [2:0] StWait     = 3'd2;
	localparam logic [2:0] StRejected = 3'd3;
	localparam logic [2:0] StIgnored  = 3'd4;

	localparam logic [1:0] RsnNone   = 2'd0;
	localparam logic [1:0] RsnWeight = 2'd1;
	localparam logic [1:0] RsnHeight = 2'd2;
	localparam logic [1:0] RsnMech   = 2'd3;

	localparam logic [1:0] TurnNone = 2'd2;

	localparam logic [1:0] RegMaxOnBridge   = 2'd0;
	localparam logic [1:0] RegMaxConsec     = 2'd1;
	localparam logic [1:0] RegMaxWeight     = 2'd2;
	localparam logic [1:0] RegMaxHeight     = 2'd3;

	localparam int unsigned AddrWidth = 4;

	typedef struct packed {
		logic [2:0] max_on_bridge;
		logic [3:0] max_consecutive;
		logic [5:0] max_weight_tons;
		logic [3:0] max_height_m;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		max_on_bridge:   3'd3,
		max_consecutive: 4'd5,
		max_weight_tons: 6'd20,
		max_height_m:    4'd4
	};

	typedef struct packed {
		logic [2:0] op;
		logic       side;
		logic [5:0] weight_tons;
		logic [3:0] height_m;
		logic       mech_fault;
		logic       car_granted;
		logic       component_ok;
	} cmd_t;

	typedef struct packed {
		logic [1:0][2:0] on_cnt;
		logic [1:0][7:0] wait_cnt;
		logic [1:0][3:0] cons_cnt;
		logic [1:0]      turn;
		logic            susp;
		logic [1:0]      sensor_ok;
		logic [1:0]      barrier_ok;
		logic [15:0]     crossed;
	} state_t;

	localparam state_t StateReset = '{
		on_cnt:     '0,
		wait_cnt:   '0,
		cons_cnt:   '0,
		turn:       TurnNone,
		susp:       1'b0,
		sensor_ok:  2'b11,
		barrier_ok: 2'b11,
		crossed:    16'd0
	};

	typedef struct packed {
		logic [2:0]  status;
		logic [1:0]  reject_reason;
		logic [1:0]  turn_now;
		logic        is_suspended;
		logic [2:0]  on_left;
		logic [2:0]  on_right;
		logic [7:0]  wait_left;
		logic [7:0]  wait_right;
		logic [15:0] crossed_total;
	} res_t;

endpackage

/* rtl/core/olba_if.sv */
// Event and result channel interfaces.
interface olba_cmd_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic       side;
	logic [5:0] weight_tons;
	logic [3:0] height_m;
	logic       mech_fault;
	logic       car_granted;
	logic       component_ok;

	modport source (output valid, op, side, weight_tons, height_m, mech_fault,
		car_granted, component_ok, input ready);
	modport sink (input valid, op, side, weight_tons, height_m, mech_fault,
		car_granted, component_ok, output ready);
endinterface

interface olba_rsp_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [1:0]  reject_reason;
	logic [1:0]  turn_now;
	logic        is_suspended;
	logic [2:0]  on_left;
	logic [2:0]  on_right;
	logic [7:0]  wait_left;
	logic [7:0]  wait_right;
	logic [15:0] crossed_total;

	modport source (output valid, status, reject_reason, turn_now, is_suspended,
		on_left, on_right, wait_left, wait_right, crossed_total, input ready);
	modport sink (input valid, status, reject_reason, turn_now, is_suspended,
		on_left, on_right, wait_left, wait_right, crossed_total, output ready);
endinterface

/* rtl/core/olba_cfg.sv */
// APB register block for the four limit registers.
module olba_cfg (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [olba_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready,
	output olba_pkg::cfg_t                 cfg
);
	import olba_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = paddr[3:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CfgReset;
		end else if (wr_en) begin
			case (reg_idx)
				RegMaxOnBridge: cfg_q.max_on_bridge   <= pwdata[2:0];
				RegMaxConsec:   cfg_q.max_consecutive <= pwdata[3:0];
				RegMaxWeight:   cfg_q.max_weight_tons <= pwdata[5:0];
				RegMaxHeight:   cfg_q.max_height_m    <= pwdata[3:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			RegMaxOnBridge: prdata = {29'd0, cfg_q.max_on_bridge};
			RegMaxConsec:   prdata = {28'd0, cfg_q.max_consecutive};
			RegMaxWeight:   prdata = {26'd0, cfg_q.max_weight_tons};
			RegMaxHeight:   prdata = {28'd0, cfg_q.max_height_m};
			default:        prdata = 32'd0;
		endcase
	end
endmodule

/* rtl/core/olba_step.sv */
// Bridge state registers and the single-event update logic.
module olba_step #(
	parameter int unsigned MAX_WAITING = olba_pkg::MaxWaitingDef
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           fire,
	input  olba_pkg::cmd_t cmd,
	input  olba_pkg::cfg_t cfg,
	output olba_pkg::res_t res
);
	import olba_pkg::*;

	localparam logic [7:0] WaitLim = (MAX_WAITING < 255) ? 8'(MAX_WAITING) : 8'd255;

	state_t     st_q;
	state_t     nx;
	logic [2:0] status;
	logic [1:0] reason;
	logic       me;
	logic       oth;
	logic       healthy;
	logic       too_heavy;
	logic       too_tall;
	logic       turn_ok;
	logic       free_ok;
	logic       cap_ok;
	logic       fair_ok;

	assign me        = cmd.side;
	assign oth       = ~cmd.side;
	assign healthy   = st_q.sensor_ok[me] && st_q.barrier_ok[me];
	assign too_heavy = cmd.weight_tons > cfg.max_weight_tons;
	assign too_tall  = cmd.height_m > cfg.max_height_m;
	assign turn_ok   = (st_q.turn == {1'b0, me}) || (st_q.turn == TurnNone);
	assign free_ok   = st_q.on_cnt[oth] == 3'd0;
	assign cap_ok    = st_q.on_cnt[me] < cfg.max_on_bridge;
	assign fair_ok   = (st_q.wait_cnt[oth] == 8'd0) ||
		(st_q.cons_cnt[me] < cfg.max_consecutive);

	always_comb begin
		nx     = st_q;
		status = StDone;
		reason = RsnNone;
		case (cmd.op)
			OpArrive: begin
				if (st_q.wait_cnt[me] < WaitLim)
					nx.wait_cnt[me] = st_q.wait_cnt[me] + 8'd1;
			end
			OpRequest: begin
				if (!healthy) begin
					status = StWait;
				end else if (too_heavy || too_tall || cmd.mech_fault) begin
					status = StRejected;
					reason = too_heavy ? RsnWeight : (too_tall ? RsnHeight : RsnMech);
					nx.susp = 1'b1;
					if (st_q.wait_cnt[me] != 8'd0)
						nx.wait_cnt[me] = st_q.wait_cnt[me] - 8'd1;
				end else if (st_q.susp || !turn_ok || !free_ok || !cap_ok || !fair_ok) begin
					status = StWait;
				end else begin
					status = StGranted;
					if (st_q.turn == TurnNone)
						nx.turn = {1'b0, me};
					if (st_q.wait_cnt[me] != 8'd0)
						nx.wait_cnt[me] = st_q.wait_cnt[me] - 8'd1;
					nx.on_cnt[me] = st_q.on_cnt[me] + 3'd1;
					if (st_q.wait_cnt[oth] != 8'd0 && st_q.cons_cnt[me] != 4'hF)
						nx.cons_cnt[me] = st_q.cons_cnt[me] + 4'd1;
				end
			end
			OpExit: begin
				if (!cmd.car_granted || st_q.on_cnt[me] == 3'd0) begin
					status = StIgnored;
				end else begin
					nx.on_cnt[me] = st_q.on_cnt[me] - 3'd1;
					if (st_q.crossed != 16'hFFFF)
						nx.crossed = st_q.crossed + 16'd1;
					// last vehicle of this side has left
					if (st_q.on_cnt[me] == 3'd1) begin
						if (st_q.cons_cnt[me] >= cfg.max_consecutive)
							nx.cons_cnt[me] = 4'd0;
						if (st_q.wait_cnt[oth] != 8'd0) begin
							nx.turn = {1'b0, oth};
						end else begin
							nx.turn = TurnNone;
							nx.cons_cnt[me] = 4'd0;
						end
					end
				end
			end
			OpSuspend: nx.susp = 1'b1;
			OpResume: begin
				nx.susp       = 1'b0;
				nx.sensor_ok  = 2'b11;
				nx.barrier_ok = 2'b11;
			end
			OpSetSensor:  nx.sensor_ok[me]  = cmd.component_ok;
			OpSetBarrier: nx.barrier_ok[me] = cmd.component_ok;
			default: status = StIgnored;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= StateReset;
		end else if (fire) begin
			st_q <= nx;
		end
	end

	assign res = '{
		status:        status,
		reject_reason: reason,
		turn_now:      nx.turn,
		is_suspended:  nx.susp,
		on_left:       nx.on_cnt[0],
		on_right:      nx.on_cnt[1],
		wait_left:     nx.wait_cnt[0],
		wait_right:    nx.wait_cnt[1],
		crossed_total: nx.crossed
	};
endmodule

/* rtl/core/one_lane_bridge_arbiter_core.sv */
// Top level: single-lane bridge direction arbiter.
// An accepted event passes through the input register and then the result register before the result is valid.
// Throughput: one event per cycle; a held result stalls the input once the input register is full.
// Reset: arst_n asynchronous, active low; counts clear, turn none, health ok, limits 3/5/20/4.
// The state update is taken when the registered event moves into the result register.
`include "assert_macros.svh"

module one_lane_bridge_arbiter_core #(
	parameter int unsigned MAX_WAITING = olba_pkg::MaxWaitingDef
) (
	input  logic                           clk,
	input  logic                           arst_n,
	olba_cmd_if.sink                       cmd,
	olba_rsp_if.source                     rsp,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [olba_pkg::AddrWidth-1:0] paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import olba_pkg::*;

	cfg_t cfg;
	cmd_t cmd_s1;
	logic valid_s1;
	res_t res;
	res_t res_q;
	logic rsp_valid_q;
	logic load;
	logic take;

	assign load      = valid_s1 && (!rsp_valid_q || rsp.ready);
	assign cmd.ready = !valid_s1 || load;
	assign take      = cmd.valid && cmd.ready;

	olba_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	olba_step #(
		.MAX_WAITING (MAX_WAITING)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (load),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.res    (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (take)
				valid_s1 <= 1'b1;
			else if (load)
				valid_s1 <= 1'b0;
			if (load)
				rsp_valid_q <= 1'b1;
			else if (rsp.ready)
				rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			cmd_s1 <= '{
				op:           cmd.op,
				side:         cmd.side,
				weight_tons:  cmd.weight_tons,
				height_m:     cmd.height_m,
				mech_fault:   cmd.mech_fault,
				car_granted:  cmd.car_granted,
				component_ok: cmd.component_ok
			};
		end
		if (load)
			res_q <= res;
	end

	assign rsp.valid         = rsp_valid_q;
	assign rsp.status        = res_q.status;
	assign rsp.reject_reason = res_q.reject_reason;
	assign rsp.turn_now      = res_q.turn_now;
	assign rsp.is_suspended  = res_q.is_suspended;
	assign rsp.on_left       = res_q.on_left;
	assign rsp.on_right      = res_q.on_right;
	assign rsp.wait_left     = res_q.wait_left;
	assign rsp.wait_right    = res_q.wait_right;
	assign rsp.crossed_total = res_q.crossed_total;

	`OLBA_ASSERT_SAME(a_one_direction, clk, arst_n, rsp_valid_q,
		(res_q.on_left == 3'd0) || (res_q.on_right == 3'd0))
	`OLBA_ASSERT_SAME(a_reason_iff_reject, clk, arst_n, rsp_valid_q,
		(res_q.status == StRejected) == (res_q.reject_reason != RsnNone))
	`OLBA_ASSERT_SAME(a_reject_suspends, clk, arst_n,
		rsp_valid_q && (res_q.status == StRejected), res_q.is_suspended)
	`OLBA_ASSERT_SAME(a_grant_has_turn, clk, arst_n,
		rsp_valid_q && (res_q.status == StGranted), res_q.turn_now != TurnNone)
endmodule
